// ----- src/u8t_pkg.sv -----
// ----------------------------------------------------------------------------
// UART 8N1 transceiver package
// Shared types and constants for the transceiver and its receive section.
// ----------------------------------------------------------------------------
package u8t_pkg;

	localparam int unsigned PERIOD_W    = 16;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned RX_FRAME_W  = 10;
	localparam int unsigned RX_COUNT_W  = 4;
	localparam int unsigned TX_FRAME_W  = 11;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 16;

	localparam logic [PERIOD_W-1:0]   PERIOD_RESET = 16'd1024;
	localparam logic [PERIOD_W-1:0]   PERIOD_MIN   = 16'd2;
	localparam logic [RX_COUNT_W-1:0] RX_LAST_BIT  = 4'd9;
	// Stop bit and end marker sit above the data byte and the start bit.
	localparam logic [1:0]            TX_TAIL_BITS = 2'b11;
	localparam logic                  TX_START_BIT = 1'b0;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_BIT_PERIOD = 1'b0,
		CFG_TX_INVERT  = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic              valid;
		logic              busy;
		logic [BYTE_W-1:0] data;
	} rx_status_t;

endpackage

// ----- src/u8t_if.sv -----
// ----------------------------------------------------------------------------
// UART 8N1 transceiver channels
// Valid/ready channels for the tick items and the status items.
// ----------------------------------------------------------------------------
interface u8t_tick_if;
	logic       valid;
	logic       ready;
	logic       rxd;
	logic       tx_start;
	logic [7:0] tx_byte;

	modport source (output valid, output rxd, output tx_start, output tx_byte, input ready);
	modport sink   (input valid, input rxd, input tx_start, input tx_byte, output ready);
endinterface

interface u8t_status_if;
	logic       valid;
	logic       ready;
	logic       txd;
	logic       tx_busy;
	logic       rx_valid;
	logic [7:0] rx_byte;
	logic       rx_busy;

	modport source (output valid, output txd, output tx_busy, output rx_valid,
		output rx_byte, output rx_busy, input ready);
	modport sink   (input valid, input txd, input tx_busy, input rx_valid,
		input rx_byte, input rx_busy, output ready);
endinterface

// ----- src/u8t_rx.sv -----
// ----------------------------------------------------------------------------
// UART 8N1 receive section
// Noise filter, start edge detection and ten-bit frame sampling.
// ----------------------------------------------------------------------------
module u8t_rx import u8t_pkg::*; #(
	parameter int unsigned FILTER_LENGTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                clear,
	input  logic                rxd,
	input  logic [PERIOD_W-1:0] tick_count,
	input  logic [PERIOD_W-1:0] period,
	output rx_status_t          status
);

	logic [FILTER_LENGTH-1:0] filter_q, filter_n;
	logic [FILTER_LENGTH:0]   filter_ext;
	logic                     level_q, level_n;
	logic                     active_q, active_n;
	logic [RX_COUNT_W-1:0]    count_q, count_n;
	logic [RX_FRAME_W-1:0]    shift_q, shift_n, shift_in;
	logic [BYTE_W-1:0]        data_q, data_n;
	logic [PERIOD_W-1:0]      sample_q, sample_n;
	logic [PERIOD_W:0]        sample_sum;
	logic                     valid_n;

	always_comb begin
		filter_ext = {filter_q, rxd};
		filter_n   = filter_ext[FILTER_LENGTH-1:0];
		level_n    = level_q;
		if (filter_n == '1) begin
			level_n = 1'b1;
		end else if (filter_n == '0) begin
			level_n = 1'b0;
		end

		shift_in   = {rxd, shift_q[RX_FRAME_W-1:1]};
		sample_sum = {1'b0, tick_count} + {2'b00, period[PERIOD_W-1:1]};
		if (sample_sum >= {1'b0, period}) begin
			sample_sum = sample_sum - {1'b0, period};
		end

		active_n = active_q;
		count_n  = count_q;
		shift_n  = shift_q;
		data_n   = data_q;
		sample_n = sample_q;
		valid_n  = 1'b0;

		// Sample the raw line at the sample point
		if (active_q && (tick_count == sample_q)) begin
			shift_n = shift_in;
			if (count_q >= RX_LAST_BIT) begin
				if (!shift_in[0] && shift_in[RX_FRAME_W-1]) begin
					data_n  = shift_in[BYTE_W:1];
					valid_n = 1'b1;
				end
				active_n = 1'b0;
				count_n  = '0;
			end else begin
				count_n = count_q + 1'b1;
			end
		end

		// Falling edge of the filtered level starts a frame
		if (!active_q && level_q && !level_n) begin
			sample_n = sample_sum[PERIOD_W-1:0];
			shift_n  = '0;
			count_n  = '0;
			active_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= '1;
			level_q  <= 1'b1;
			active_q <= 1'b0;
			count_q  <= '0;
			shift_q  <= '0;
			data_q   <= '0;
			sample_q <= '0;
		end else begin
			if (step) begin
				filter_q <= filter_n;
				level_q  <= level_n;
				active_q <= active_n;
				count_q  <= count_n;
				shift_q  <= shift_n;
				data_q   <= data_n;
				sample_q <= sample_n;
			end
			if (clear) begin
				active_q <= 1'b0;
				count_q  <= '0;
			end
		end
	end

	assign status.valid = valid_n;
	assign status.busy  = active_n;
	assign status.data  = data_n;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= RX_LAST_BIT)
		else $error("receive bit count past frame length");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (count_q == '0))
		else $error("receive bit count nonzero while idle");

	a_sample_in_period: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (sample_q < period))
		else $error("sample point outside bit period");

endmodule

// ----- src/uart_8n1_transceiver_unit.sv -----
// ----------------------------------------------------------------------------
// UART 8N1 transceiver unit
// Timer-tick driven 8N1 receiver and transmitter with an output register.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake      payload
//  tick      in    valid/ready    rxd, tx_start, tx_byte[7:0]
//  status    out   valid/ready    txd, tx_busy, rx_valid, rx_byte[7:0], rx_busy
//  cfg       in    cfg_wen only   cfg_index, cfg_wdata[15:0]
//
//  One tick item is taken per cycle while the output register is free or
//  draining; its status item appears in the output register on the next cycle.
//  All state updates run in one pass of logic between the state registers
//  and the output register; the half-period add with wrap sets the path.
//  A stalled status item holds the register; tick.ready stays high while the
//  register is empty or being drained, so no cycle is lost under streaming.
//  Reset is asynchronous: period 1024, inverted transmit, receiver idle.
//
module uart_8n1_transceiver_unit import u8t_pkg::*; #(
	parameter int unsigned FILTER_LENGTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	u8t_tick_if.sink               tick,
	u8t_status_if.source           status,
	input  logic                   cfg_wen,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	// Configuration registers
	logic [PERIOD_W-1:0] bit_period_q;
	logic                tx_invert_q;
	logic                period_clear;

	// Tick state
	logic [PERIOD_W-1:0]   tick_count_q, tick_count_n;
	logic [TX_FRAME_W-1:0] tx_frame_q, tx_frame_n;
	logic                  tx_line_q, tx_line_n;

	// Output register
	logic              out_valid_q;
	logic              txd_q, tx_busy_q, rx_valid_q, rx_busy_q;
	logic [BYTE_W-1:0] rx_byte_q;

	logic                step;
	logic                wrap;
	logic [PERIOD_W-1:0] period;
	rx_status_t          rx_status;

	// Accept a tick whenever the output register is free or draining
	assign tick.ready = !out_valid_q || status.ready;
	assign step       = tick.valid && tick.ready;

	assign period = (bit_period_q < PERIOD_MIN) ? PERIOD_MIN : bit_period_q;
	assign wrap   = tick_count_q >= (period - 1'b1);

	assign period_clear = cfg_wen && (cfg_index_t'(cfg_index) == CFG_BIT_PERIOD);

	u8t_rx #(
		.FILTER_LENGTH (FILTER_LENGTH)
	) u_rx (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.clear      (period_clear),
		.rxd        (tick.rxd),
		.tick_count (tick_count_q),
		.period     (period),
		.status     (rx_status)
	);

	// Transmit shift on wrap, load when idle, then advance the counter
	always_comb begin
		tx_frame_n = tx_frame_q;
		tx_line_n  = tx_line_q;
		if (tx_frame_q != '0) begin
			if (wrap) begin
				tx_line_n  = tx_frame_q[0] ^ tx_invert_q;
				tx_frame_n = {1'b0, tx_frame_q[TX_FRAME_W-1:1]};
			end
		end else if (tick.tx_start) begin
			// A byte loaded on a wrap goes out from the next wrap on
			tx_frame_n = {TX_TAIL_BITS, tick.tx_byte, TX_START_BIT};
		end

		if (wrap) begin
			tick_count_n = '0;
		end else begin
			tick_count_n = tick_count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= PERIOD_RESET;
			tx_invert_q  <= 1'b1;
			tick_count_q <= '0;
			tx_frame_q   <= '0;
			tx_line_q    <= 1'b0;
		end else begin
			if (step) begin
				tick_count_q <= tick_count_n;
				tx_frame_q   <= tx_frame_n;
				tx_line_q    <= tx_line_n;
			end
			if (cfg_wen) begin
				case (cfg_index_t'(cfg_index))
					CFG_BIT_PERIOD: begin
						// New period restarts the counter; receiver drops its frame
						bit_period_q <= cfg_wdata[PERIOD_W-1:0];
						tick_count_q <= '0;
					end
					CFG_TX_INVERT: begin
						tx_invert_q <= cfg_wdata[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			txd_q      <= tx_line_n;
			tx_busy_q  <= (tx_frame_n != '0);
			rx_valid_q <= rx_status.valid;
			rx_byte_q  <= rx_status.data;
			rx_busy_q  <= rx_status.busy;
		end
	end

	assign status.valid    = out_valid_q;
	assign status.txd      = txd_q;
	assign status.tx_busy  = tx_busy_q;
	assign status.rx_valid = rx_valid_q;
	assign status.rx_byte  = rx_byte_q;
	assign status.rx_busy  = rx_busy_q;

	a_tick_in_period: assert property (@(posedge clk) disable iff (!arst_n)
		tick_count_q < period)
		else $error("tick counter outside bit period");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!tick.ready |-> out_valid_q)
		else $error("tick item refused with empty output register");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rx_valid_q) |-> !rx_busy_q)
		else $error("receive byte delivered while frame still active");

endmodule
